/* hdl/mc4_pkg.sv */
// ----------------------------------------------------------------------------
// mc4_pkg - shared types for the 4x4 matrix column transform
// Operation codes, the request tag that travels with each item, and the
// vector dimension.
// ----------------------------------------------------------------------------
`default_nettype none

package mc4_pkg;

    localparam int N_DIM = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_MUL    = 2'd1,
        OP_MUL_TR = 2'd2
    } t_op;

    // op is kept as raw bits so the unused code passes through untouched
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] col;
    } t_tag;

endpackage

`default_nettype wire

/* hdl/mc4_in_if.sv */
// ----------------------------------------------------------------------------
// mc4_in_if - request channel of the matrix column transform
// Valid/ready handshake with the op, the column index and four elements.
// ----------------------------------------------------------------------------
`default_nettype none

interface mc4_in_if #(
    parameter int ELEM_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [1:0]                   column_index;
    logic signed [ELEM_WIDTH-1:0] elem_0;
    logic signed [ELEM_WIDTH-1:0] elem_1;
    logic signed [ELEM_WIDTH-1:0] elem_2;
    logic signed [ELEM_WIDTH-1:0] elem_3;

    modport source (output valid, op, column_index, elem_0, elem_1, elem_2, elem_3,
                    input ready);
    modport sink   (input valid, op, column_index, elem_0, elem_1, elem_2, elem_3,
                    output ready);
endinterface

`default_nettype wire

/* hdl/mc4_out_if.sv */
// ----------------------------------------------------------------------------
// mc4_out_if - result channel of the matrix column transform
// Valid/ready handshake with four result elements and the saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mc4_out_if #(
    parameter int ELEM_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] out_0;
    logic signed [ELEM_WIDTH-1:0] out_1;
    logic signed [ELEM_WIDTH-1:0] out_2;
    logic signed [ELEM_WIDTH-1:0] out_3;
    logic                         saturated;

    modport source (output valid, out_0, out_1, out_2, out_3, saturated, input ready);
    modport sink   (input valid, out_0, out_1, out_2, out_3, saturated, output ready);
endinterface

`default_nettype wire

/* hdl/matrix4_column_transform.sv */
// ----------------------------------------------------------------------------
// matrix4_column_transform - 4x4 matrix times vector in signed fixed point
// Top level: a chain of four multiply-accumulate cells and a rounding stage.
// ----------------------------------------------------------------------------
// The block holds a 4x4 matrix (column-major, identity after reset) and takes
// one request per clock: op 0 loads a column, op 1 returns M*v, op 2 returns
// M^T*v; op 3 is ignored. Each of the four cells keeps one column and one row
// of the matrix and carries four ELEM_WIDTH x ELEM_WIDTH multipliers. A
// request passes the product and the sum register of every cell, then the
// rounding register; the chain sustains one request per cycle as long as
// results are taken. A stall at the output backs up stage by stage, so
// empty stages still take new requests. Loads travel the chain in order, so
// every multiply sees the matrix as left by all earlier requests. Sums are
// exact, then rounded to nearest and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_column_transform #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mc4_in_if.sink     i_in,
    mc4_out_if.source  o_out
);
    import mc4_pkg::*;

    localparam int ACC_W = 2*ELEM_WIDTH + 2;

    logic                         s_valid [N_DIM+1];
    logic                         s_ready [N_DIM+1];
    t_tag                         s_tag   [N_DIM+1];
    logic signed [ELEM_WIDTH-1:0] s_vec   [N_DIM+1][N_DIM];
    logic signed [ACC_W-1:0]      s_acc   [N_DIM+1][N_DIM];
    logic signed [ELEM_WIDTH-1:0] s_elem  [N_DIM];

    assign s_valid[0] = i_in.valid;
    assign i_in.ready = s_ready[0];
    assign s_tag[0]   = '{op: i_in.op, col: i_in.column_index};
    assign s_vec[0]   = '{i_in.elem_0, i_in.elem_1, i_in.elem_2, i_in.elem_3};
    assign s_acc[0]   = '{default: '0};

    for (genvar k = 0; k < N_DIM; k++) begin : g_cell
        mc4_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .COL        (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_tag   (s_tag[k]),
            .i_vec   (s_vec[k]),
            .i_acc   (s_acc[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_tag   (s_tag[k+1]),
            .o_vec   (s_vec[k+1]),
            .o_acc   (s_acc[k+1])
        );
    end

    mc4_finish #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_valid[N_DIM]),
        .o_ready     (s_ready[N_DIM]),
        .i_tag       (s_tag[N_DIM]),
        .i_acc       (s_acc[N_DIM]),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_elem      (s_elem),
        .o_saturated (o_out.saturated)
    );

    assign o_out.out_0 = s_elem[0];
    assign o_out.out_1 = s_elem[1];
    assign o_out.out_2 = s_elem[2];
    assign o_out.out_3 = s_elem[3];

`ifndef SYNTHESIS
    localparam logic signed [ELEM_WIDTH-1:0] A_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] A_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // a free output must let the whole chain take a new request
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("request refused while output is free");

    // a flagged result carries at least one clipped element
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
            (o_out.out_0 == A_MAX || o_out.out_0 == A_MIN ||
             o_out.out_1 == A_MAX || o_out.out_1 == A_MIN ||
             o_out.out_2 == A_MAX || o_out.out_2 == A_MIN ||
             o_out.out_3 == A_MAX || o_out.out_3 == A_MIN))
        else $error("saturation flag without a clipped element");

    // the first cell cannot stall while the chain behind it drains
    a_cell_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ready[1] |-> s_ready[0])
        else $error("first cell stalled with a free successor");
`endif

endmodule

`default_nettype wire

/* hdl/mc4_cell.sv */
// ----------------------------------------------------------------------------
// mc4_cell - one multiply-accumulate cell of the transform chain
// Holds column COL and row COL of the matrix, multiplies them by vector
// element COL in the first stage and adds the products to the running row
// sums in the second stage. Loads update the local copies in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module mc4_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COL        = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire mc4_pkg::t_tag                  i_tag,
    input  wire logic signed [ELEM_WIDTH-1:0]   i_vec [mc4_pkg::N_DIM],
    input  wire logic signed [2*ELEM_WIDTH+1:0] i_acc [mc4_pkg::N_DIM],
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output mc4_pkg::t_tag                       o_tag,
    output logic signed [ELEM_WIDTH-1:0]        o_vec [mc4_pkg::N_DIM],
    output logic signed [2*ELEM_WIDTH+1:0]      o_acc [mc4_pkg::N_DIM]
);
    import mc4_pkg::*;

    localparam int ACC_W  = 2*ELEM_WIDTH + 2;
    localparam int PROD_W = 2*ELEM_WIDTH;
    localparam logic signed [ELEM_WIDTH-1:0] ONE_Q = ELEM_WIDTH'(1) << FRAC_BITS;

    // local slice of the matrix: r_col[r] = M(r, COL), r_row[r] = M(COL, r)
    logic signed [ELEM_WIDTH-1:0] r_col [N_DIM];
    logic signed [ELEM_WIDTH-1:0] r_row [N_DIM];

    logic                         r_a_valid;
    t_tag                         r_a_tag;
    logic signed [ELEM_WIDTH-1:0] r_a_vec  [N_DIM];
    logic signed [ACC_W-1:0]      r_a_acc  [N_DIM];
    logic signed [PROD_W-1:0]     r_a_prod [N_DIM];

    logic                         r_b_valid;
    t_tag                         r_b_tag;
    logic signed [ELEM_WIDTH-1:0] r_b_vec [N_DIM];
    logic signed [ACC_W-1:0]      r_b_acc [N_DIM];

    logic signed [PROD_W-1:0]     n_prod [N_DIM];
    logic signed [ACC_W-1:0]      n_acc  [N_DIM];
    logic                         s_a_ready;
    logic                         s_b_ready;
    logic                         s_a_take;
    logic                         s_b_take;

    assign s_b_ready = !r_b_valid || i_ready;
    assign s_a_ready = !r_a_valid || s_b_ready;
    assign s_a_take  = i_valid && s_a_ready;
    assign s_b_take  = r_a_valid && s_b_ready;

    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            if (i_tag.op == OP_MUL) begin
                n_prod[r] = r_col[r] * i_vec[COL];
            end else begin
                n_prod[r] = r_row[r] * i_vec[COL];
            end
            n_acc[r] = r_a_acc[r] + {{(ACC_W-PROD_W){r_a_prod[r][PROD_W-1]}}, r_a_prod[r]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            for (int r = 0; r < N_DIM; r++) begin
                r_col[r] <= (r == COL) ? ONE_Q : '0;
                r_row[r] <= (r == COL) ? ONE_Q : '0;
            end
        end else begin
            if (s_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (s_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (s_a_take && i_tag.op == OP_LOAD) begin
                if (i_tag.col == 2'(COL)) begin
                    r_col <= i_vec;
                end
                r_row[i_tag.col] <= i_vec[COL];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_a_take) begin
            r_a_tag  <= i_tag;
            r_a_vec  <= i_vec;
            r_a_acc  <= i_acc;
            r_a_prod <= n_prod;
        end
        if (s_b_take) begin
            r_b_tag <= r_a_tag;
            r_b_vec <= r_a_vec;
            r_b_acc <= n_acc;
        end
    end

    assign o_ready = s_a_ready;
    assign o_valid = r_b_valid;
    assign o_tag   = r_b_tag;
    assign o_vec   = r_b_vec;
    assign o_acc   = r_b_acc;

endmodule

`default_nettype wire

/* hdl/mc4_finish.sv */
// ----------------------------------------------------------------------------
// mc4_finish - rounding, saturation and result register
// Rounds each row sum to nearest, drops the fraction, clips to the element
// range and holds the result until the sink takes it. Loads end here.
// ----------------------------------------------------------------------------
`default_nettype none

module mc4_finish #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire mc4_pkg::t_tag                  i_tag,
    input  wire logic signed [2*ELEM_WIDTH+1:0] i_acc [mc4_pkg::N_DIM],
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [ELEM_WIDTH-1:0]        o_elem [mc4_pkg::N_DIM],
    output logic                                o_saturated
);
    import mc4_pkg::*;

    localparam int ACC_W = 2*ELEM_WIDTH + 2;
    localparam int SUM_W = ACC_W + 1;
    localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] MAX_S =
        {{(SUM_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_S =
        {{(SUM_W-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};
    localparam logic signed [ELEM_WIDTH-1:0] MAX_E = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] MIN_E = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic                         r_valid;
    logic signed [ELEM_WIDTH-1:0] r_elem [N_DIM];
    logic                         r_saturated;

    logic signed [SUM_W-1:0]      n_sum   [N_DIM];
    logic signed [SUM_W-1:0]      n_shift [N_DIM];
    logic signed [ELEM_WIDTH-1:0] n_elem  [N_DIM];
    logic                         n_saturated;
    logic                         s_ready;
    logic                         s_is_mul;

    assign s_ready  = !r_valid || i_ready;
    assign s_is_mul = (i_tag.op == OP_MUL) || (i_tag.op == OP_MUL_TR);

    always_comb begin
        n_saturated = 1'b0;
        for (int r = 0; r < N_DIM; r++) begin
            n_sum[r]   = {i_acc[r][ACC_W-1], i_acc[r]} + RND;
            n_shift[r] = n_sum[r] >>> FRAC_BITS;
            if (n_shift[r] > MAX_S) begin
                n_elem[r]   = MAX_E;
                n_saturated = 1'b1;
            end else if (n_shift[r] < MIN_S) begin
                n_elem[r]   = MIN_E;
                n_saturated = 1'b1;
            end else begin
                n_elem[r] = n_shift[r][ELEM_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_ready) begin
            // loads and the unused code leave no result
            r_valid <= i_valid && s_is_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_valid) begin
            r_elem      <= n_elem;
            r_saturated <= n_saturated;
        end
    end

    assign o_ready     = s_ready;
    assign o_valid     = r_valid;
    assign o_elem      = r_elem;
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

/* tb/tb_matrix4_column_transform.sv */
// ----------------------------------------------------------------------------
// tb_matrix4_column_transform - self-checking bench for the 4x4 transform
// Loads matrix columns and sends M*v and M^T*v requests. A scoreboard keeps
// its own copy of the matrix, computes each expected vector with exact sums,
// rounding and saturation, and compares every result in order. Both channels
// idle at random over several phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix4_column_transform;
    import mc4_pkg::*;

    localparam int EW   = 32;
    localparam int FRAC = 16;

    // unused op code: the block drops it without a result
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC - 1);
    localparam logic signed [127:0] ELEM_MAX   = (128'sd1 <<< (EW - 1)) - 128'sd1;
    localparam logic signed [127:0] ELEM_MIN   = -(128'sd1 <<< (EW - 1));

    localparam logic [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] E_ONE = EW'(1) << FRAC;

    localparam int MAX_REPORTS = 50;

    typedef logic [3:0][EW-1:0] t_vec;

    typedef struct packed {
        t_vec vals;
        logic sat;
    } t_result;

    class matrix_scoreboard;
        logic signed [EW-1:0] matrix [16];
        t_result expected_vectors [$];
        int n_errors;
        int n_loads;
        int n_mul;
        int n_mul_tr;
        int n_ignored;
        int n_results;
        int n_sat;

        function new();
            for (int i = 0; i < 16; i++) begin
                matrix[i] = (i % 5 == 0) ? E_ONE : '0;
            end
        endfunction

        function automatic t_result apply_matrix(logic [1:0] op, t_vec v);
            logic signed [127:0] acc;
            logic signed [127:0] a;
            logic signed [127:0] b;
            t_result r;
            int idx;
            r.sat = 1'b0;
            for (int row = 0; row < 4; row++) begin
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    idx = (op == OP_MUL) ? (k * 4 + row) : (row * 4 + k);
                    a   = $signed(matrix[idx]);
                    b   = $signed(v[k]);
                    acc = acc + a * b;
                end
                acc = (acc + ROUND_HALF) >>> FRAC;
                if (acc > ELEM_MAX) begin
                    r.vals[row] = E_MAX;
                    r.sat       = 1'b1;
                end else if (acc < ELEM_MIN) begin
                    r.vals[row] = E_MIN;
                    r.sat       = 1'b1;
                end else begin
                    r.vals[row] = acc[EW-1:0];
                end
            end
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [1:0] col, t_vec v);
            if (op == OP_LOAD) begin
                for (int k = 0; k < 4; k++) matrix[col * 4 + k] = v[k];
                n_loads++;
            end else if (op == OP_MUL || op == OP_MUL_TR) begin
                expected_vectors.push_back(apply_matrix(op, v));
                if (op == OP_MUL) n_mul++;
                else n_mul_tr++;
            end else begin
                n_ignored++;
            end
        endfunction

        function void report(string field, logic [EW-1:0] exp_val, logic [EW-1:0] act_val);
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h actual %h",
                         $time, field, exp_val, act_val);
        endfunction

        function void check_result(t_result got);
            t_result exp_res;
            n_results++;
            if (got.sat) n_sat++;
            if (expected_vectors.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none actual %h %h %h %h sat %b",
                             $time, got.vals[0], got.vals[1], got.vals[2], got.vals[3],
                             got.sat);
                return;
            end
            exp_res = expected_vectors.pop_front();
            for (int k = 0; k < 4; k++) begin
                if (got.vals[k] !== exp_res.vals[k])
                    report($sformatf("out_%0d", k), exp_res.vals[k], got.vals[k]);
            end
            if (got.sat !== exp_res.sat)
                report("saturated", EW'(exp_res.sat), EW'(got.sat));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mc4_in_if  #(.ELEM_WIDTH(EW)) req_if ();
    mc4_out_if #(.ELEM_WIDTH(EW)) res_if ();

    matrix4_column_transform #(
        .ELEM_WIDTH(EW),
        .FRAC_BITS (FRAC)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (res_if)
    );

    matrix_scoreboard sb = new();

    int      in_idle_pct;
    int      out_stall_pct;
    int      n_sent;
    t_result got_res;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // check results before noting requests of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got_res.vals[0] = res_if.out_0;
                got_res.vals[1] = res_if.out_1;
                got_res.vals[2] = res_if.out_2;
                got_res.vals[3] = res_if.out_3;
                got_res.sat     = res_if.saturated;
                sb.check_result(got_res);
            end
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.op, req_if.column_index,
                                {req_if.elem_3, req_if.elem_2, req_if.elem_1, req_if.elem_0});
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [1:0] col,
                                input logic [EW-1:0] e0, input logic [EW-1:0] e1,
                                input logic [EW-1:0] e2, input logic [EW-1:0] e3);
        while ($urandom_range(99) < in_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.column_index <= col;
        req_if.elem_0       <= e0;
        req_if.elem_1       <= e1;
        req_if.elem_2       <= e2;
        req_if.elem_3       <= e3;
        do @(posedge i_clk); while (!req_if.ready);
        n_sent++;
    endtask

    function automatic logic [EW-1:0] rand_elem();
        case ($urandom_range(9))
            0, 1, 2, 3: return EW'(int'($urandom_range(1 << 19)) - (1 << 18));
            4, 5:       return EW'($urandom);
            6, 7:       return EW'(int'($urandom_range(1 << 25)) - (1 << 24));
            default: begin
                case ($urandom_range(5))
                    0:       return E_MAX;
                    1:       return E_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return EW'(1);
                    default: return E_ONE;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_load(input logic [1:0] col);
        send_request(OP_LOAD, col, rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endtask

    initial begin
        int count;
        int pick;
        logic [1:0] op;

        req_if.valid        <= 1'b0;
        req_if.op           <= OP_LOAD;
        req_if.column_index <= '0;
        req_if.elem_0       <= '0;
        req_if.elem_1       <= '0;
        req_if.elem_2       <= '0;
        req_if.elem_3       <= '0;
        i_rst_n             <= 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        n_sent        = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity matrix passes vectors through unchanged
        send_request(OP_MUL, 2'd0, E_MAX, E_MIN, '0, '1);
        send_request(OP_MUL_TR, 2'd3, EW'(1), EW'(32768), -E_ONE, E_MIN);
        send_request(OP_NONE, 2'd2, E_MAX, E_MAX, E_MAX, E_MAX);

        // all-max matrix: clip high and low
        for (int c = 0; c < 4; c++) send_request(OP_LOAD, 2'(c), E_MAX, E_MAX, E_MAX, E_MAX);
        send_request(OP_MUL, 2'd1, E_MAX, E_MAX, E_MAX, E_MAX);
        send_request(OP_MUL, 2'd2, E_MIN, E_MIN, E_MIN, E_MIN);
        send_request(OP_MUL_TR, 2'd0, E_MAX, E_MIN, E_MAX, E_MIN);

        // all-min matrix times all-min vector: largest positive sum
        for (int c = 3; c >= 0; c--) send_request(OP_LOAD, 2'(c), E_MIN, E_MIN, E_MIN, E_MIN);
        send_request(OP_MUL, 2'd3, E_MIN, E_MIN, E_MIN, E_MIN);

        // rounding ties on both signs, then a vec3 transform with w = 1.0
        send_request(OP_LOAD, 2'd0, EW'(1), '1, E_ONE, '0);
        send_request(OP_LOAD, 2'd1, '0, '0, '0, '0);
        send_request(OP_LOAD, 2'd2, '0, '0, E_ONE, '0);
        send_request(OP_LOAD, 2'd3, EW'(3) << FRAC, '0, '0, E_ONE);
        send_request(OP_MUL, 2'd0, EW'(32768), '0, '0, '0);
        send_request(OP_MUL, 2'd2, -EW'(32768), '0, '0, '0);
        send_request(OP_MUL_TR, 2'd1, EW'(32768), -EW'(32769), E_MAX, E_ONE);
        send_request(OP_MUL, 2'd3, E_MIN, E_MAX, '1, E_ONE);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 87; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 87; end
                default: begin in_idle_pct = 26; out_stall_pct = 26; end
            endcase
            count = 0;
            while (count < 482) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    // full reload followed by a matrix-matrix style burst
                    for (int c = 0; c < 4; c++) send_random_load(2'(c));
                    for (int k = 0; k < 4; k++)
                        send_request(OP_MUL, 2'($urandom), rand_elem(), rand_elem(),
                                     rand_elem(), rand_elem());
                    count += 8;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 20)      op = OP_LOAD;
                    else if (pick < 58) op = OP_MUL;
                    else if (pick < 96) op = OP_MUL_TR;
                    else                op = OP_NONE;
                    send_request(op, 2'($urandom), rand_elem(), rand_elem(),
                                 rand_elem(), rand_elem());
                    if (op != OP_NONE) count++;
                end
            end
        end

        req_if.valid <= 1'b0;
        while (sb.expected_vectors.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests: %0d loads, %0d M*v, %0d M^T*v, %0d dropped",
                 n_sent, sb.n_loads, sb.n_mul, sb.n_mul_tr, sb.n_ignored);
        $display("Checked %0d result vectors, %0d of them clipped", sb.n_results, sb.n_sat);
        if (sb.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout waiting for the block");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/mc4_pkg.sv
hdl/mc4_in_if.sv
hdl/mc4_out_if.sv
hdl/mc4_cell.sv
hdl/mc4_finish.sv
hdl/matrix4_column_transform.sv
tb/tb_matrix4_column_transform.sv
